@@ hdl/mpa_pkg.sv @@
// mpa_pkg: shared constants and types of the max pooling argmax unit
// used by mpa_max_unit and max_pooling_2d_argmax_unit; depends on nothing

package mpa_pkg;

   localparam int MAX_HEIGHT   = 64;
   localparam int MAX_WIDTH    = 64;
   localparam int MAX_CHANNELS = 16;
   localparam int MAX_KERNEL   = 8;
   localparam int MAX_STEP     = 8;
   localparam int DATA_WIDTH   = 32;

   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int CHAN_W  = 4;
   localparam int POS_W   = 6;
   localparam int ADDR_W  = ROW_W + COL_W + CHAN_W;
   localparam int DEPTH   = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;

   // register indexes of the configuration port
   localparam logic [2:0] REG_IN_HEIGHT    = 3'd0;
   localparam logic [2:0] REG_IN_WIDTH     = 3'd1;
   localparam logic [2:0] REG_NUM_CHANNELS = 3'd2;
   localparam logic [2:0] REG_KERNEL_SIZE  = 3'd3;
   localparam logic [2:0] REG_PAD_AMOUNT   = 3'd4;
   localparam logic [2:0] REG_STEP_SIZE    = 3'd5;

   // action codes of the request beat
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // one tap handed from the sequencer to the compare unit
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             in_image;
      logic [POS_W-1:0] pos;
   } tap_type;

endpackage

@@ hdl/mpa_max_unit.sv @@
// mpa_max_unit: shared signed compare unit that keeps the running window maximum
// depends on mpa_pkg

module mpa_max_unit
   import mpa_pkg::*;
(
   input  logic                         clock,
   input  tap_type                      tap,
   input  logic signed [DATA_WIDTH-1:0] tap_data,
   output logic signed [DATA_WIDTH-1:0] best_value,
   output logic [POS_W-1:0]             best_pos
);

   logic signed [DATA_WIDTH-1:0] best_ff;
   logic signed [DATA_WIDTH-1:0] best_in;
   logic [POS_W-1:0]             pos_ff;
   logic [POS_W-1:0]             pos_in;
   logic signed [DATA_WIDTH-1:0] value;
   logic                         take;

   // padding taps read as zero; first tap always wins, later ones only if strictly greater
   always_comb begin
      value   = tap.in_image ? tap_data : '0;
      take    = tap.valid && (tap.first || (value > best_ff));
      best_in = take ? value : best_ff;
      pos_in  = take ? tap.pos : pos_ff;
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      pos_ff  <= pos_in;
   end

   assign best_value = best_ff;
   assign best_pos   = pos_ff;

endmodule

@@ hdl/max_pooling_2d_argmax_unit.sv @@
// max_pooling_2d_argmax_unit: pixel store, window sequencer and result register
// depends on mpa_pkg and mpa_max_unit
//
// usage
//  - csr port: write csr_data into register csr_index when csr_write is high;
//    registers are height, width, channels, kernel, padding, stride
//  - req channel: a write beat (action 0) stores pixel_value at row, column,
//    channel; a query beat (action 1) names an output window
//  - rsp channel: one beat per query with the maximum, its tap index and a
//    range flag; writes give no rsp beat
//  - a query passes from accept to rsp_valid through a range check, one
//    store read per tap through the single read port of the pixel store,
//    the last compare and the load of the result register; a range error
//    goes straight from the range check to the result register
//  - req_stall is low only while the sequencer is idle, so one query is in
//    work at a time; the next req beat is taken once the query has loaded
//    the result register; writes are taken back to back
//  - a result waiting under rsp_stall does not block a new request; a query
//    that finishes meanwhile holds until the result register frees up
//  - reset clears the control state and the registers to their defaults;
//    store contents are undefined until written, there is no clearing pass

module max_pooling_2d_argmax_unit
   import mpa_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [2:0]                   csr_index,
   input  logic [6:0]                   csr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [ROW_W-1:0]             req_row_pos,
   input  logic [COL_W-1:0]             req_col_pos,
   input  logic [CHAN_W-1:0]            req_chan_pos,
   input  logic signed [DATA_WIDTH-1:0] req_pixel_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_max_value,
   output logic [POS_W-1:0]             rsp_max_position,
   output logic                         rsp_range_error
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   // configuration registers
   logic [6:0] in_height_ff;
   logic [6:0] in_width_ff;
   logic [4:0] num_channels_ff;
   logic [3:0] kernel_size_ff;
   logic [2:0] pad_amount_ff;
   logic [3:0] step_size_ff;

   // clamped settings
   logic [6:0] h_c;
   logic [6:0] w_c;
   logic [4:0] c_c;
   logic [3:0] k_c;
   logic [3:0] s_c;
   logic [2:0] kmax;

   state_type                    state_ff, state_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [CHAN_W-1:0]            chan_ff, chan_in;
   logic signed [10:0]           y_ff, y_in;
   logic signed [10:0]           x_ff, x_in;
   logic signed [10:0]           x0_ff, x0_in;
   logic [2:0]                   m_ff, m_in;
   logic [2:0]                   n_ff, n_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic                         err_ff, err_in;
   tap_type                      tap_ff, tap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]             rsp_pos_ff, rsp_pos_in;
   logic                         rsp_err_ff, rsp_err_in;

   logic                         req_take;
   logic [7:0]                   span_h;
   logic [7:0]                   span_w;
   logic [9:0]                   row_end;
   logic [9:0]                   col_end;
   logic                         range_bad;
   logic                         in_image;
   logic [ADDR_W-1:0]            rd_addr;
   logic                         out_free;
   logic signed [DATA_WIDTH-1:0] best_value;
   logic [POS_W-1:0]             best_pos;

   // pixel store
   logic signed [DATA_WIDTH-1:0] store_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff    <= 7'd1;
         in_width_ff     <= 7'd1;
         num_channels_ff <= 5'd1;
         kernel_size_ff  <= 4'd2;
         pad_amount_ff   <= 3'd0;
         step_size_ff    <= 4'd1;
      end else if (csr_write) begin
         case (csr_index)
            REG_IN_HEIGHT:    in_height_ff    <= csr_data;
            REG_IN_WIDTH:     in_width_ff     <= csr_data;
            REG_NUM_CHANNELS: num_channels_ff <= csr_data[4:0];
            REG_KERNEL_SIZE:  kernel_size_ff  <= csr_data[3:0];
            REG_PAD_AMOUNT:   pad_amount_ff   <= csr_data[2:0];
            REG_STEP_SIZE:    step_size_ff    <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // clamp settings into their legal ranges, zero becomes one
   always_comb begin
      h_c = (in_height_ff == '0) ? 7'd1 :
            (in_height_ff > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : in_height_ff;
      w_c = (in_width_ff == '0) ? 7'd1 :
            (in_width_ff > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : in_width_ff;
      c_c = (num_channels_ff == '0) ? 5'd1 :
            (num_channels_ff > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : num_channels_ff;
      k_c = (kernel_size_ff == '0) ? 4'd1 :
            (kernel_size_ff > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kernel_size_ff;
      s_c = (step_size_ff == '0) ? 4'd1 :
            (step_size_ff > 4'(MAX_STEP)) ? 4'(MAX_STEP) : step_size_ff;
      kmax = 3'(k_c - 4'd1);
   end

   // window range check: row < out_size exactly when row*stride + kernel <= span
   always_comb begin
      span_h    = 8'(h_c) + 8'({pad_amount_ff, 1'b0});
      span_w    = 8'(w_c) + 8'({pad_amount_ff, 1'b0});
      row_end   = 10'(row_ff) * 10'(s_c) + 10'(k_c);
      col_end   = 10'(col_ff) * 10'(s_c) + 10'(k_c);
      range_bad = (5'(chan_ff) >= c_c) ||
                  (row_end > 10'(span_h)) || (col_end > 10'(span_w));
   end

   // tap address and padding test
   always_comb begin
      in_image = !y_ff[10] && !x_ff[10] &&
                 (y_ff < 11'(h_c)) && (x_ff < 11'(w_c));
      rd_addr  = {y_ff[ROW_W-1:0], x_ff[COL_W-1:0], chan_ff};
   end

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // store write and registered read
   always_ff @(posedge clock) begin
      if (req_take && (req_action == ACT_WRITE)) begin
         store_mem[{req_row_pos, req_col_pos, req_chan_pos}] <= req_pixel_value;
      end
      if (state_ff == ST_SCAN) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      chan_in      = chan_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      x0_in        = x0_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      tap_in       = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_action == ACT_QUERY)) begin
               row_in   = req_row_pos;
               col_in   = req_col_pos;
               chan_in  = req_chan_pos;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            err_in = range_bad;
            y_in   = 11'(row_end) - 11'(k_c) - 11'(pad_amount_ff);
            x_in   = 11'(col_end) - 11'(k_c) - 11'(pad_amount_ff);
            x0_in  = 11'(col_end) - 11'(k_c) - 11'(pad_amount_ff);
            m_in   = '0;
            n_in   = '0;
            pos_in = '0;
            state_in = range_bad ? ST_HOLD : ST_SCAN;
         end
         ST_SCAN: begin
            tap_in.valid    = 1'b1;
            tap_in.first    = (pos_ff == '0);
            tap_in.in_image = in_image;
            tap_in.pos      = pos_ff;
            pos_in          = pos_ff + 1'b1;
            if (n_ff == kmax) begin
               n_in = '0;
               x_in = x0_ff;
               m_in = m_ff + 1'b1;
               y_in = y_ff + 11'sd1;
               if (m_ff == kmax) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               n_in = n_ff + 1'b1;
               x_in = x_ff + 11'sd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = err_ff ? '0 : best_value;
               rsp_pos_in   = err_ff ? '0 : best_pos;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      chan_ff      <= chan_in;
      y_ff         <= y_in;
      x_ff         <= x_in;
      x0_ff        <= x0_in;
      m_ff         <= m_in;
      n_ff         <= n_in;
      pos_ff       <= pos_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // running maximum over the taps
   mpa_max_unit u_max (
      .clock      (clock),
      .tap        (tap_ff),
      .tap_data   (rd_data_ff),
      .best_value (best_value),
      .best_pos   (best_pos)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_value    = rsp_value_ff;
   assign rsp_max_position = rsp_pos_ff;
   assign rsp_range_error  = rsp_err_ff;

endmodule

@@ tb/max_pooling_2d_argmax_unit_test.sv @@
// max_pooling_2d_argmax_unit_test: self-checking testbench of the max pooling argmax unit
// drives pixel writes and window queries, predicts every rsp beat from a mirror of the store
// depends on mpa_pkg and max_pooling_2d_argmax_unit
`timescale 1ns / 1ps

module max_pooling_2d_argmax_unit_test;
   import mpa_pkg::*;

   localparam int RANDOM_ITEMS  = 1500;
   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 300;
   localparam int CYCLE_LIMIT   = 2000000;

   // one predicted rsp beat
   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic [POS_W-1:0]             position;
      logic                         range_err;
   } pool_result_type;

   // register settings after clamping, plus the output size they give
   typedef struct {
      int h, w, c, k, p, s;
      int rows, cols;
   } geom_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_write;
   logic [2:0]                   csr_index;
   logic [6:0]                   csr_data;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_action;
   logic [ROW_W-1:0]             req_row_pos;
   logic [COL_W-1:0]             req_col_pos;
   logic [CHAN_W-1:0]            req_chan_pos;
   logic signed [DATA_WIDTH-1:0] req_pixel_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [DATA_WIDTH-1:0] rsp_max_value;
   logic [POS_W-1:0]             rsp_max_position;
   logic                         rsp_range_error;

   // mirror of the pixel store and of the registers
   logic signed [DATA_WIDTH-1:0] image_mirror [DEPTH];
   bit                           image_filled [DEPTH];
   int cfg_height, cfg_width, cfg_channels, cfg_kernel, cfg_pad, cfg_step;

   pool_result_type pending_results[$];

   int  fail_count;
   int  beats_sent;
   int  writes_sent;
   int  queries_sent;
   int  range_sent;
   int  settings_used;
   int  cycle_count;
   bit  steady_send;
   bit  rsp_steady;
   bit  hold_req;
   int  hold_left;

   max_pooling_2d_argmax_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_row_pos      (req_row_pos),
      .req_col_pos      (req_col_pos),
      .req_chan_pos     (req_chan_pos),
      .req_pixel_value  (req_pixel_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_value    (rsp_max_value),
      .rsp_max_position (rsp_max_position),
      .rsp_range_error  (rsp_range_error)
   );

   // clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("max_pooling_2d_argmax_unit_test: errors");
         $finish;
      end
   end

   // rsp side stall: random, steady stretches, and one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req <= 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 38);
      end
   end

   // compare each rsp beat with the oldest prediction
   always @(posedge clock) begin
      pool_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("rsp beat with no query outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_max_value !== want.value) begin
               $error("max_value expected %0d actual %0d", want.value, rsp_max_value);
               fail_count++;
            end
            if (rsp_max_position !== want.position) begin
               $error("max_position expected %0d actual %0d", want.position,
                      rsp_max_position);
               fail_count++;
            end
            if (rsp_range_error !== want.range_err) begin
               $error("range_error expected %0d actual %0d", want.range_err,
                      rsp_range_error);
               fail_count++;
            end
         end
      end
   end

   function automatic int clamp_reg(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int out_span(int n, int k, int p, int s);
      if (n + 2 * p < k) return 0;
      return (n + 2 * p - k) / s + 1;
   endfunction

   function automatic int store_index(int y, int x, int ch);
      return (y * MAX_WIDTH + x) * MAX_CHANNELS + ch;
   endfunction

   function automatic geom_type current_geom();
      geom_type g;
      g.h    = clamp_reg(cfg_height, MAX_HEIGHT);
      g.w    = clamp_reg(cfg_width, MAX_WIDTH);
      g.c    = clamp_reg(cfg_channels, MAX_CHANNELS);
      g.k    = clamp_reg(cfg_kernel, MAX_KERNEL);
      g.s    = clamp_reg(cfg_step, MAX_STEP);
      g.p    = cfg_pad;
      g.rows = out_span(g.h, g.k, g.p, g.s);
      g.cols = out_span(g.w, g.k, g.p, g.s);
      return g;
   endfunction

   function automatic bit window_in_range(geom_type g, int row, int col, int ch);
      return row < g.rows && col < g.cols && ch < g.c;
   endfunction

   // window maximum with argmax, padding reads as zero, first of equal values wins
   function automatic pool_result_type predict_window(int row, int col, int ch);
      pool_result_type r;
      geom_type     g;
      int           y, x;
      logic signed [DATA_WIDTH-1:0] v;
      bit           have;
      g           = current_geom();
      r.value     = '0;
      r.position  = '0;
      r.range_err = 1'b1;
      if (!window_in_range(g, row, col, ch)) return r;
      r.range_err = 1'b0;
      have        = 1'b0;
      for (int m = 0; m < g.k; m++) begin
         for (int n = 0; n < g.k; n++) begin
            y = row * g.s + m - g.p;
            x = col * g.s + n - g.p;
            v = '0;
            if (y >= 0 && y < g.h && x >= 0 && x < g.w)
               v = image_mirror[store_index(y, x, ch)];
            if (!have || v > r.value) begin
               r.value    = v;
               r.position = POS_W'(m * g.k + n);
               have       = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // pixel values weighted toward extremes and small values that tie
   function automatic logic signed [DATA_WIDTH-1:0] rand_pixel();
      case ($urandom_range(7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3, 4: return int'($urandom_range(8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // drive one req beat at the falling edge, hold it until accepted
   task automatic send_beat(logic act, int row, int col, int ch,
                            logic signed [DATA_WIDTH-1:0] value);
      while (!steady_send && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_row_pos     <= ROW_W'(row);
      req_col_pos     <= COL_W'(col);
      req_chan_pos    <= CHAN_W'(ch);
      req_pixel_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (act == ACT_WRITE) begin
         image_mirror[store_index(row, col, ch)] = value;
         image_filled[store_index(row, col, ch)] = 1'b1;
         writes_sent++;
      end else begin
         pending_results.push_back(predict_window(row, col, ch));
         queries_sent++;
         if (pending_results[$].range_err) range_sent++;
      end
      @(negedge clock);
   endtask

   // a query, preceded by writes to any in-image tap never written
   task automatic pool_query(int row, int col, int ch);
      geom_type g;
      int    y, x;
      g = current_geom();
      if (window_in_range(g, row, col, ch)) begin
         for (int m = 0; m < g.k; m++) begin
            for (int n = 0; n < g.k; n++) begin
               y = row * g.s + m - g.p;
               x = col * g.s + n - g.p;
               if (y >= 0 && y < g.h && x >= 0 && x < g.w &&
                   !image_filled[store_index(y, x, ch)])
                  send_beat(ACT_WRITE, y, x, ch, rand_pixel());
            end
         end
      end
      send_beat(ACT_QUERY, row, col, ch, $urandom);
   endtask

   // sender pauses until every predicted beat has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= 7'(value);
      case (idx)
         REG_IN_HEIGHT:    cfg_height   = value & 7'h7f;
         REG_IN_WIDTH:     cfg_width    = value & 7'h7f;
         REG_NUM_CHANNELS: cfg_channels = value & 5'h1f;
         REG_KERNEL_SIZE:  cfg_kernel   = value & 4'hf;
         REG_PAD_AMOUNT:   cfg_pad      = value & 3'h7;
         REG_STEP_SIZE:    cfg_step     = value & 4'hf;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // new register setting, only once the unit has gone quiet
   task automatic configure(int h, int w, int c, int k, int p, int s);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(REG_IN_HEIGHT, h);
      write_reg(REG_IN_WIDTH, w);
      write_reg(REG_NUM_CHANNELS, c);
      write_reg(REG_KERNEL_SIZE, k);
      write_reg(REG_PAD_AMOUNT, p);
      write_reg(REG_STEP_SIZE, s);
      csr_write <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   task automatic set_steady(bit on);
      steady_send = on;
      rsp_steady  <= on;
   endtask

   // reset defaults: 1x1 image under a 2x2 window has no output at all
   task automatic test_reset_defaults();
      pool_query(0, 0, 0);
      pool_query(63, 63, 15);
   endtask

   // largest image, window, padding and stride; then a one-tap window
   task automatic test_extremes();
      configure(64, 64, 16, 8, 7, 8);
      send_beat(ACT_WRITE, 0, 0, 0, 32'sh7fffffff);
      send_beat(ACT_WRITE, 63, 63, 15, 32'sh80000000);
      pool_query(0, 0, 0);
      pool_query(8, 8, 15);
      pool_query(9, 0, 0);
      pool_query(0, 63, 15);
      configure(1, 1, 1, 1, 0, 1);
      pool_query(0, 0, 0);
      pool_query(1, 0, 0);
   endtask

   // zero and oversize register values clamp to their limits
   task automatic test_clamped_regs();
      configure(0, 0, 0, 0, 7, 0);
      pool_query(7, 7, 0);
      pool_query(14, 14, 0);
      pool_query(15, 0, 0);
      configure(127, 127, 31, 15, 0, 15);
      pool_query(7, 7, 15);
      pool_query(8, 0, 0);
   endtask

   // equal values keep the first tap; padding zero beats later zeros and negatives
   task automatic test_ties_and_padding();
      configure(3, 3, 2, 2, 0, 1);
      for (int y = 0; y < 3; y++)
         for (int x = 0; x < 3; x++) begin
            send_beat(ACT_WRITE, y, x, 1, 5);
            send_beat(ACT_WRITE, y, x, 0, -7);
         end
      send_beat(ACT_WRITE, 5, 5, 1, 42);
      pool_query(1, 1, 1);
      pool_query(0, 0, 2);
      configure(3, 3, 2, 3, 1, 1);
      send_beat(ACT_WRITE, 1, 1, 0, 0);
      pool_query(0, 0, 0);
      pool_query(1, 1, 1);
   endtask

   // rsp held off for a long stretch while queries keep coming
   task automatic test_backpressure();
      configure(4, 4, 1, 2, 0, 1);
      for (int y = 0; y < 4; y++)
         for (int x = 0; x < 4; x++)
            send_beat(ACT_WRITE, y, x, 0, rand_pixel());
      set_steady(1'b1);
      hold_req <= 1'b1;
      for (int i = 0; i < 8; i++)
         pool_query(i % 3, (i / 3) % 3, 0);
      drain_results();
      set_steady(1'b0);
   endtask

   // random settings, each with a mix of writes and queries
   task automatic test_random_traffic();
      geom_type g;
      int    first, n_items, pick, rows_cap, cols_cap;
      first = beats_sent;
      while (beats_sent - first < RANDOM_ITEMS) begin
         pick = $urandom_range(5);
         if (pick == 0)
            configure($urandom_range(32, 64), $urandom_range(32, 64), $urandom_range(1, 16),
                      $urandom_range(1, 4), $urandom_range(0, 7), $urandom_range(1, 8));
         else if (pick == 1)
            configure($urandom_range(127), $urandom_range(127), $urandom_range(31),
                      $urandom_range(15), $urandom_range(7), $urandom_range(15));
         else
            configure($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1, 4),
                      $urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(1, 3));
         set_steady(settings_used % 5 == 2);
         g        = current_geom();
         rows_cap = (g.rows > 64) ? 64 : g.rows;
         cols_cap = (g.cols > 64) ? 64 : g.cols;
         n_items  = $urandom_range(30, 120);
         for (int i = 0; i < n_items && beats_sent - first < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 25)
               send_beat(ACT_WRITE, $urandom_range(g.h - 1), $urandom_range(g.w - 1),
                         $urandom_range(g.c - 1), rand_pixel());
            else if (pick < 35)
               send_beat(ACT_WRITE, $urandom_range(63), $urandom_range(63),
                         $urandom_range(15), $urandom);
            else if (pick < 90 && rows_cap > 0 && cols_cap > 0)
               pool_query($urandom_range(rows_cap - 1), $urandom_range(cols_cap - 1),
                          $urandom_range(g.c - 1));
            else
               pool_query($urandom_range(63), $urandom_range(63), $urandom_range(15));
            if ($urandom_range(199) == 0) drain_results();
         end
      end
      set_steady(1'b0);
   endtask

   initial begin
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = REG_IN_HEIGHT;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_action      = ACT_WRITE;
      req_row_pos     = '0;
      req_col_pos     = '0;
      req_chan_pos    = '0;
      req_pixel_value = '0;
      rsp_stall       = 1'b0;
      rsp_steady      = 1'b0;
      hold_req        = 1'b0;
      steady_send     = 1'b0;
      cfg_height      = 1;
      cfg_width       = 1;
      cfg_channels    = 1;
      cfg_kernel      = 2;
      cfg_pad         = 0;
      cfg_step        = 1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_extremes();
      test_clamped_regs();
      test_ties_and_padding();
      test_backpressure();
      test_random_traffic();

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("covered %0d pixel writes and %0d window queries (%0d out of range)",
               writes_sent, queries_sent, range_sent);
      $display("across %0d register settings in %0d cycles", settings_used, cycle_count);
      if (fail_count == 0)
         $display("max_pooling_2d_argmax_unit_test: clean");
      else
         $display("max_pooling_2d_argmax_unit_test: errors");
      $finish;
   end

endmodule
